[sv/bxds_pkg.sv]
// Shared constants, types and register codes of the box-average downscaler.
`timescale 1ns / 1ps
package bxds_pkg;

  localparam int unsigned MaxSrcWidth = 4096;
  localparam int unsigned Channels    = 4;
  localparam int unsigned PixW        = 8;
  localparam int unsigned SumW        = 12;              // line store entry per channel
  localparam int unsigned AccW        = 10;              // up to four pixels along a row
  localparam int unsigned NumW        = SumW + 1;        // sum plus rounding term
  localparam int unsigned ColW        = $clog2(MaxSrcWidth);
  localparam int unsigned WidthW      = 13;
  localparam int unsigned RowW        = 16;
  localparam int unsigned FactorW     = 3;
  localparam int unsigned PaddrW      = 4;
  localparam int unsigned PdataW      = 32;

  localparam logic [FactorW-1:0] FactorReset = 3'd2;
  localparam logic [WidthW-1:0]  WidthReset  = 13'd640;
  localparam logic [RowW-1:0]    HeightReset = 16'd480;

  // reciprocals for divide by 3 and by 9
  localparam logic [11:0] Recip3Col   = 12'd2731;   // >> 13, exact below 4096
  localparam logic [15:0] Recip3Row   = 16'd43691;  // >> 17, exact below 65536
  localparam logic [NumW-1:0] Recip9  = 13'd7282;   // >> 16, exact below 8192

  typedef enum logic [1:0] {
    RegFactor    = 2'd0,
    RegSrcWidth  = 2'd1,
    RegSrcHeight = 2'd2
  } reg_idx_e;

  typedef logic [Channels-1:0][PixW-1:0] pix_t;
  typedef logic [Channels-1:0][AccW-1:0] acc_t;
  typedef logic [Channels-1:0][SumW-1:0] sum_t;
  typedef logic [Channels-1:0][NumW-1:0] num_t;

endpackage

[sv/bxds_pix_in_if.sv]
// Source pixel channel: valid/ready handshake with four 8-bit channels.
`timescale 1ns / 1ps
interface bxds_pix_in_if;
  import bxds_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] in_blue;
  logic [PixW-1:0] in_green;
  logic [PixW-1:0] in_red;
  logic [PixW-1:0] in_alpha;

  modport source (output valid, output in_blue, output in_green, output in_red,
                  output in_alpha, input ready);
  modport sink   (input valid, input in_blue, input in_green, input in_red,
                  input in_alpha, output ready);
endinterface

[sv/bxds_pix_out_if.sv]
// Output pixel channel: valid/ready handshake, averaged channels and end flags.
`timescale 1ns / 1ps
interface bxds_pix_out_if;
  import bxds_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] out_blue;
  logic [PixW-1:0] out_green;
  logic [PixW-1:0] out_red;
  logic [PixW-1:0] out_alpha;
  logic            row_end;
  logic            frame_end;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output out_alpha, output row_end, output frame_end, input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input out_alpha, input row_end, input frame_end, output ready);
endinterface

[sv/bxds_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bxds_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/box_average_downscaler_core.sv]
// Box-average downscaler: every factor-by-factor block of raster-order source pixels
// becomes one output pixel, each channel (sum + area/2) / area. The core takes one
// source pixel per clock unless the output stalls it; a result passes the
// line-store write stage, the divide stage and the output register after the pixel
// that closes its block, and backpressure on the output stalls the input only once
// all of them are occupied. The per-column partial sums live in one 4096 x 48 line
// store that is read when a block row closes and written back from the write stage;
// the next access to the same column comes at least two pixels later, so read and
// write never overlap. The store needs no clearing: the top band of each block
// overwrites it. Registers (APB, byte address 4*i): factor at 0x0, source width at
// 0x4, source height at 0x8; write them only while no pixel is in flight.
`timescale 1ns / 1ps
module box_average_downscaler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bxds_pkg::PaddrW-1:0]   paddr,
  input  logic [bxds_pkg::PdataW-1:0]   pwdata,
  output logic [bxds_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  bxds_pix_in_if.sink                   src_i,
  bxds_pix_out_if.source                dst_o
);
  import bxds_pkg::*;

  // ---------------------------------------------------------------- helpers
  function automatic logic [2:0] eff_factor(logic [FactorW-1:0] f);
    logic [2:0] r;
    if (f == '0) r = 3'd1;
    else if (f > 3'd4) r = 3'd4;
    else r = f;
    return r;
  endfunction

  function automatic logic [WidthW-1:0] eff_width(logic [WidthW-1:0] w);
    logic [WidthW-1:0] r;
    if (w == '0) r = WidthW'(1);
    else if (w > WidthW'(MaxSrcWidth)) r = WidthW'(MaxSrcWidth);
    else r = w;
    return r;
  endfunction

  function automatic logic [RowW-1:0] eff_height(logic [RowW-1:0] h);
    return (h == '0) ? RowW'(1) : h;
  endfunction

  function automatic logic [WidthW-1:0] width_div(logic [WidthW-1:0] w, logic [2:0] f);
    logic [WidthW+11:0] prod;
    logic [WidthW-1:0]  r;
    prod = (WidthW+12)'(w) * (WidthW+12)'(Recip3Col);
    case (f)
      3'd1:    r = w;
      3'd2:    r = w >> 1;
      3'd3:    r = WidthW'(prod >> 13);
      default: r = w >> 2;
    endcase
    return r;
  endfunction

  function automatic logic [RowW-1:0] height_div(logic [RowW-1:0] h, logic [2:0] f);
    logic [2*RowW-1:0] prod;
    logic [RowW-1:0]   r;
    prod = (2*RowW)'(h) * (2*RowW)'(Recip3Row);
    case (f)
      3'd1:    r = h;
      3'd2:    r = h >> 1;
      3'd3:    r = RowW'(prod >> 17);
      default: r = h >> 2;
    endcase
    return r;
  endfunction

  function automatic logic [ColW-1:0] col_div(logic [ColW-1:0] c, logic [2:0] f);
    logic [ColW+11:0] prod;
    logic [ColW-1:0]  r;
    prod = (ColW+12)'(c) * (ColW+12)'(Recip3Col);
    case (f)
      3'd1:    r = c;
      3'd2:    r = c >> 1;
      3'd3:    r = ColW'(prod >> 13);
      default: r = c >> 2;
    endcase
    return r;
  endfunction

  function automatic logic [WidthW-1:0] width_mul(logic [WidthW-1:0] d, logic [2:0] f);
    logic [WidthW-1:0] r;
    case (f)
      3'd1:    r = d;
      3'd2:    r = d << 1;
      3'd3:    r = (d << 1) + d;
      default: r = d << 2;
    endcase
    return r;
  endfunction

  function automatic logic [RowW-1:0] height_mul(logic [RowW-1:0] d, logic [2:0] f);
    logic [RowW-1:0] r;
    case (f)
      3'd1:    r = d;
      3'd2:    r = d << 1;
      3'd3:    r = (d << 1) + d;
      default: r = d << 2;
    endcase
    return r;
  endfunction

  function automatic logic [PixW-1:0] area_div(logic [NumW-1:0] n, logic [2:0] f);
    logic [2*NumW-1:0] prod;
    logic [PixW-1:0]   r;
    prod = (2*NumW)'(n) * (2*NumW)'(Recip9);
    case (f)
      3'd1:    r = PixW'(n);
      3'd2:    r = PixW'(n >> 2);
      3'd3:    r = PixW'(prod >> 16);
      default: r = PixW'(n >> 4);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- config port
  logic [FactorW-1:0] factor_q, factor_d;
  logic [WidthW-1:0]  width_q, width_d;
  logic [RowW-1:0]    height_q, height_d;
  logic [WidthW-1:0]  dw_q, col_lim_q;
  logic [RowW-1:0]    dh_q, row_lim_q;
  logic [2:0]         fd_eff;
  logic [WidthW-1:0]  dw_d;
  logic [RowW-1:0]    dh_d;
  logic               cfg_we;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[PaddrW-1:2]);

  always_comb begin
    factor_d = factor_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we) begin
      case (cfg_idx)
        RegFactor:    factor_d = pwdata[FactorW-1:0];
        RegSrcWidth:  width_d  = pwdata[WidthW-1:0];
        RegSrcHeight: height_d = pwdata[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegFactor:    prdata = PdataW'(factor_q);
      RegSrcWidth:  prdata = PdataW'(width_q);
      RegSrcHeight: prdata = PdataW'(height_q);
      default:      prdata = '0;
    endcase
  end

  // output size and block-aligned limits, derived from the values being written
  assign fd_eff = eff_factor(factor_d);
  assign dw_d   = width_div(eff_width(width_d), fd_eff);
  assign dh_d   = height_div(eff_height(height_d), fd_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q  <= FactorReset;
      width_q   <= WidthReset;
      height_q  <= HeightReset;
      dw_q      <= width_div(eff_width(WidthReset), eff_factor(FactorReset));
      col_lim_q <= width_mul(width_div(eff_width(WidthReset), eff_factor(FactorReset)),
                             eff_factor(FactorReset));
      dh_q      <= height_div(eff_height(HeightReset), eff_factor(FactorReset));
      row_lim_q <= height_mul(height_div(eff_height(HeightReset), eff_factor(FactorReset)),
                              eff_factor(FactorReset));
    end else if (cfg_we) begin
      factor_q  <= factor_d;
      width_q   <= width_d;
      height_q  <= height_d;
      dw_q      <= dw_d;
      col_lim_q <= width_mul(dw_d, fd_eff);
      dh_q      <= dh_d;
      row_lim_q <= height_mul(dh_d, fd_eff);
    end
  end

  logic [2:0]        f_eff;
  logic [WidthW-1:0] w_eff;
  logic [RowW-1:0]   h_eff;
  logic [NumW-1:0]   half_area;

  assign f_eff = eff_factor(factor_q);
  assign w_eff = eff_width(width_q);
  assign h_eff = eff_height(height_q);

  always_comb begin
    case (f_eff)
      3'd1:    half_area = NumW'(0);
      3'd2:    half_area = NumW'(2);
      3'd3:    half_area = NumW'(4);
      default: half_area = NumW'(8);
    endcase
  end

  // ---------------------------------------------------------------- handshake
  logic out_valid_q, s2_valid_q, s3_valid_q;
  logic s2_last_q;
  logic out_en, s3_free, s2_go, s2_free, in_acc;

  assign out_en  = !out_valid_q || dst_o.ready;
  assign s3_free = !s3_valid_q || out_en;
  assign s2_go   = s2_valid_q && (!s2_last_q || s3_free);
  assign s2_free = !s2_valid_q || s2_go;
  assign src_i.ready = s2_free;
  assign in_acc  = src_i.valid && s2_free;

  // ---------------------------------------------------------------- stage 1: counters
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [1:0]      cphase_q, cphase_d, rphase_q, rphase_d;
  acc_t            acc_q, acc_d, acc_new;
  pix_t            pix_in;
  logic            in_blk, cp_last, rp_last, blk_done, row_last, frame_last;
  logic [ColW-1:0] ox;
  logic [RowW-1:0] oy;
  logic            row_end_flag, frame_end_flag;

  assign pix_in[0] = src_i.in_blue;
  assign pix_in[1] = src_i.in_green;
  assign pix_in[2] = src_i.in_red;
  assign pix_in[3] = src_i.in_alpha;

  assign in_blk     = (WidthW'(col_q) < col_lim_q) && (row_q < row_lim_q);
  assign cp_last    = (3'(cphase_q) + 3'd1) >= f_eff;
  assign rp_last    = (3'(rphase_q) + 3'd1) >= f_eff;
  assign blk_done   = in_blk && cp_last;
  assign row_last   = (WidthW'(col_q) + WidthW'(1)) >= w_eff;
  assign frame_last = ((RowW+1)'(row_q) + (RowW+1)'(1)) >= (RowW+1)'(h_eff);

  assign ox = col_div(col_q, f_eff);
  assign oy = height_div(row_q, f_eff);
  assign row_end_flag   = (WidthW'(ox) + WidthW'(1)) >= dw_q;
  assign frame_end_flag = row_end_flag &&
                          (((RowW+1)'(oy) + (RowW+1)'(1)) >= (RowW+1)'(dh_q));

  always_comb begin
    for (int k = 0; k < Channels; k++) begin
      acc_new[k] = (cphase_q == '0) ? AccW'(pix_in[k]) : acc_q[k] + AccW'(pix_in[k]);
    end
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    cphase_d = cphase_q;
    rphase_d = rphase_q;
    acc_d    = acc_q;
    if (in_acc) begin
      if (in_blk) begin
        if (cp_last) begin
          cphase_d = '0;
          acc_d    = '0;
        end else begin
          cphase_d = cphase_q + 2'd1;
          acc_d    = acc_new;
        end
      end
      if (row_last) begin
        col_d    = '0;
        cphase_d = '0;
        acc_d    = '0;
        if (frame_last) begin
          row_d    = '0;
          rphase_d = '0;
        end else begin
          row_d    = row_q + RowW'(1);
          rphase_d = rp_last ? 2'd0 : rphase_q + 2'd1;
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      cphase_q <= '0;
      rphase_q <= '0;
      acc_q    <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      cphase_q <= cphase_d;
      rphase_q <= rphase_d;
      acc_q    <= acc_d;
    end
  end

  // ---------------------------------------------------------------- stage 2: line store RMW
  acc_t            s2_acc_q;
  logic            s2_rpnz_q, s2_row_end_q, s2_frame_end_q;
  logic [ColW-1:0] s2_ox_q;
  sum_t            rdata, sum_new;
  num_t            num_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= in_acc && blk_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && blk_done) begin
      s2_acc_q       <= acc_new;
      s2_rpnz_q      <= (rphase_q != '0);
      s2_ox_q        <= ox;
      s2_last_q      <= rp_last;
      s2_row_end_q   <= row_end_flag;
      s2_frame_end_q <= frame_end_flag;
    end
  end

  bxds_ram #(
    .Width (Channels * SumW),
    .Depth (MaxSrcWidth)
  ) u_col_sums (
    .clk_i   (clk_i),
    .we_i    (s2_go),
    .waddr_i (s2_ox_q),
    .wdata_i (sum_new),
    .re_i    (in_acc),
    .raddr_i (ox),
    .rdata_o (rdata)
  );

  // top band of a block starts a fresh column sum; sums wrap at 12 bits
  always_comb begin
    for (int k = 0; k < Channels; k++) begin
      sum_new[k] = SumW'(s2_acc_q[k]) + (s2_rpnz_q ? rdata[k] : SumW'(0));
      num_new[k] = NumW'(sum_new[k]) + half_area;
    end
  end

  // ---------------------------------------------------------------- stage 3: divide
  num_t       s3_num_q;
  logic [2:0] s3_f_q;
  logic       s3_row_end_q, s3_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_free) begin
      s3_valid_q <= s2_go && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free && s2_go && s2_last_q) begin
      s3_num_q       <= num_new;
      s3_f_q         <= f_eff;
      s3_row_end_q   <= s2_row_end_q;
      s3_frame_end_q <= s2_frame_end_q;
    end
  end

  // ---------------------------------------------------------------- output register
  pix_t out_pix_q;
  logic out_row_end_q, out_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s3_valid_q) begin
      for (int k = 0; k < Channels; k++) begin
        out_pix_q[k] <= area_div(s3_num_q[k], s3_f_q);
      end
      out_row_end_q   <= s3_row_end_q;
      out_frame_end_q <= s3_frame_end_q;
    end
  end

  assign dst_o.valid     = out_valid_q;
  assign dst_o.out_blue  = out_pix_q[0];
  assign dst_o.out_green = out_pix_q[1];
  assign dst_o.out_red   = out_pix_q[2];
  assign dst_o.out_alpha = out_pix_q[3];
  assign dst_o.row_end   = out_row_end_q;
  assign dst_o.frame_end = out_frame_end_q;

endmodule

[tb/sv/tb_box_average_downscaler_core.sv]
// Testbench for the box-average downscaler core: random frames checked against a predictor.
`timescale 1ns / 1ps
module tb_box_average_downscaler_core;
  import bxds_pkg::*;

  localparam int unsigned SettleCycles = 16;    // covers the three-stage output pipe
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StuckLimit   = 4000;
  localparam int unsigned LongRow      = 200;
  localparam int unsigned RandomPixels = 1000;

  typedef struct {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
    logic [PixW-1:0] alpha;
    logic            row_end;
    logic            frame_end;
  } scaled_pix_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  bxds_pix_in_if  src_if ();
  bxds_pix_out_if dst_if ();

  box_average_downscaler_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .src_i   (src_if.sink),
    .dst_o   (dst_if.source)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [FactorW-1:0] cfg_factor = FactorReset;
  logic [WidthW-1:0]  cfg_width  = WidthReset;
  logic [RowW-1:0]    cfg_height = HeightReset;
  sum_t               col_sum [MaxSrcWidth];
  int unsigned        row_acc [Channels] = '{default: 0};
  int unsigned        cur_col = 0;
  int unsigned        cur_row = 0;
  int unsigned        col_ph  = 0;
  int unsigned        row_ph  = 0;

  pix_t        source_q [$];
  scaled_pix_t scaled_q [$];
  pix_t        offered_pix;
  int unsigned mismatch_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned dst_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned stuck_cycles = 0;

  function automatic int unsigned eff_factor(input logic [FactorW-1:0] v);
    if (v == 0) return 1;
    if (v > 4) return 4;
    return v;
  endfunction

  function automatic int unsigned eff_width(input logic [WidthW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxSrcWidth) return MaxSrcWidth;
    return v;
  endfunction

  function automatic int unsigned eff_height(input logic [RowW-1:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic pix_t random_pixel();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  // Folds one source pixel into the block sums; queues an output pixel when a block closes.
  function automatic void accumulate_source_pixel(input pix_t px);
    int unsigned f, w, h, dw, dh, area, ox, oy, s;
    int          k;
    pix_t        avg;
    scaled_pix_t res;
    f    = eff_factor(cfg_factor);
    w    = eff_width(cfg_width);
    h    = eff_height(cfg_height);
    dw   = w / f;
    dh   = h / f;
    area = f * f;
    if (cur_col < dw * f && cur_row < dh * f) begin
      ox = (cur_col / f) % MaxSrcWidth;
      oy = cur_row / f;
      for (k = 0; k < Channels; k++) begin
        row_acc[k] = (col_ph == 0) ? px[k] : row_acc[k] + px[k];
      end
      if (col_ph + 1 >= f) begin
        for (k = 0; k < Channels; k++) begin
          s = row_acc[k];
          if (row_ph != 0) s += col_sum[ox][k];
          col_sum[ox][k] = SumW'(s);
          row_acc[k] = 0;
        end
        col_ph = 0;
        if (row_ph + 1 >= f) begin
          for (k = 0; k < Channels; k++) begin
            avg[k] = PixW'((col_sum[ox][k] + area / 2) / area);
          end
          res.blue      = avg[0];
          res.green     = avg[1];
          res.red       = avg[2];
          res.alpha     = avg[3];
          res.row_end   = (ox + 1 >= dw);
          res.frame_end = (ox + 1 >= dw) && (oy + 1 >= dh);
          scaled_q.push_back(res);
        end
      end else begin
        col_ph++;
      end
    end
    if (cur_col + 1 >= w) begin
      cur_col = 0;
      col_ph  = 0;
      row_acc = '{default: 0};
      if (cur_row + 1 >= h) begin
        cur_row = 0;
        row_ph  = 0;
      end else begin
        cur_row = cur_row + 1;
        row_ph  = (row_ph + 1 >= f) ? 0 : row_ph + 1;
      end
    end else begin
      cur_col = cur_col + 1;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // pixel driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (src_if.valid && src_if.ready) accumulate_source_pixel(offered_pix);
      if (!src_if.valid || src_if.ready) begin
        if (source_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          offered_pix = source_q.pop_front();
          src_if.valid    <= 1'b1;
          src_if.in_blue  <= offered_pix[0];
          src_if.in_green <= offered_pix[1];
          src_if.in_red   <= offered_pix[2];
          src_if.in_alpha <= offered_pix[3];
        end else begin
          src_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started by a toggle of hold_req
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= HoldCycles;
      hold_ack  <= hold_req;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    scaled_pix_t want;
    if (rst_ni) begin
      if (dst_if.valid && dst_if.ready) begin
        if (scaled_q.size() == 0) begin
          $error("output pixel transfer with none expected");
          mismatch_cnt++;
        end else begin
          want = scaled_q.pop_front();
          check_field("out_blue", want.blue, dst_if.out_blue);
          check_field("out_green", want.green, dst_if.out_green);
          check_field("out_red", want.red, dst_if.out_red);
          check_field("out_alpha", want.alpha, dst_if.out_alpha);
          check_field("row_end", want.row_end, dst_if.row_end);
          check_field("frame_end", want.frame_end, dst_if.frame_end);
        end
      end
      dst_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= dst_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready) ||
        (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [PdataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegFactor:    cfg_factor = val[FactorW-1:0];
      RegSrcWidth:  cfg_width  = val[WidthW-1:0];
      RegSrcHeight: cfg_height = val[RowW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // wait until every pixel is in and every output pixel is out, then let the pipe empty
  task automatic settle();
    @(negedge clk_i);
    while (source_q.size() != 0 || src_if.valid || scaled_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic push_random(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) source_q.push_back(random_pixel());
  endtask

  initial begin
    int unsigned fac, wid, hgt, npix, sent, frame_no;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    src_if.valid    = 1'b0;
    src_if.in_blue  = '0;
    src_if.in_green = '0;
    src_if.in_red   = '0;
    src_if.in_alpha = '0;
    dst_if.ready    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 31;
    dst_stall_pct = 31;
    // reset register values: part of a 2x2 block row, then shrink the width under it
    push_random(3);
    settle();
    write_reg(RegSrcWidth, 2);
    push_random(3);
    settle();
    // factor 0 acts as 1, height 0 as 1; row counter is past the new bound
    write_reg(RegFactor, 0);
    write_reg(RegSrcHeight, 0);
    push_random(2);
    source_q.push_back('1);
    source_q.push_back('0);
    settle();
    // factor above 4 and width 0: image smaller than one block
    write_reg(RegFactor, 5);
    write_reg(RegSrcWidth, 0);
    push_random(1);
    settle();
    // 3x3 of full-scale pixels plus a dropped column
    write_reg(RegFactor, 3);
    write_reg(RegSrcWidth, 4);
    write_reg(RegSrcHeight, 3);
    repeat (12) source_q.push_back('1);
    settle();
    // width beyond the line store, then cut back in mid-row
    write_reg(RegFactor, 1);
    write_reg(RegSrcWidth, 8191);
    write_reg(RegSrcHeight, 1);
    push_random(2);
    settle();
    write_reg(RegSrcWidth, 4);
    push_random(2);
    settle();

    // one long row at factor 1, with a long output hold-off while pixels keep coming
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    write_reg(RegSrcWidth, LongRow);
    push_random(LongRow);
    hold_req = ~hold_req;
    settle();

    sent     = 0;
    frame_no = 0;
    while (sent < RandomPixels) begin
      case (frame_no % 4)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 73; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 73; end
        default: begin src_idle_pct = 31; dst_stall_pct = 31; end
      endcase
      fac = $urandom_range(0, 7);
      wid = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 20);
      hgt = $urandom_range(0, 12);
      write_reg(RegFactor, fac);
      write_reg(RegSrcWidth, wid);
      write_reg(RegSrcHeight, hgt);
      npix = eff_width(WidthW'(wid)) * eff_height(RowW'(hgt));
      push_random(npix);
      sent += npix;
      frame_no++;
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
